// ===== design/dlsp_pkg.sv =====
// Shared types and constants for the delimited label stream parser.
// Holds the result record, the delimiter/field codes and the header keyword table.
// No dependencies.
package dlsp_pkg;

   // Stream byte codes
   localparam logic [7:0] BYTE_RECORD_END = 8'h00;
   localparam logic [7:0] BYTE_PAD        = 8'h01;
   localparam logic [7:0] BYTE_MEMBER_END = 8'h02;
   localparam logic [7:0] BYTE_HEADER_END = 8'h03;
   localparam logic [7:0] BYTE_TEXT_MIN   = 8'h04;

   // Delimiter kind codes
   localparam logic [1:0] DELIM_NONE   = 2'd0;
   localparam logic [1:0] DELIM_HEADER = 2'd1;
   localparam logic [1:0] DELIM_MEMBER = 2'd2;
   localparam logic [1:0] DELIM_RECORD = 2'd3;

   // Field kind codes
   localparam logic [2:0] KIND_UNKNOWN = 3'd7;
   localparam int         NUM_KEYS     = 7;

   // Number reader phases
   typedef enum logic [1:0] {
      PHASE_BLANKS  = 2'd0,
      PHASE_SIGN    = 2'd1,
      PHASE_DIGITS  = 2'd2,
      PHASE_STOPPED = 2'd3
   } num_phase_type;

   // Keywords, byte i in bits 8i+7:8i (first character lowest)
   typedef logic [63:0] key_word_type;
   localparam key_word_type KEY_TEXT [NUM_KEYS] = '{
      64'h656d_616e_656c_6966,  // filename
      64'h0000_0065_6c74_6974,  // title
      64'h0073_7473_6974_7261,  // artists
      64'h0000_7365_726e_6567,  // genres
      64'h0000_736d_7562_6c61,  // albums
      64'h6f66_6e69_6572_6f6d,  // moreinfo
      64'h0064_6961_6964_656d   // mediaid
   };
   localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{
      4'd8, 4'd5, 4'd7, 4'd6, 4'd6, 4'd8, 4'd7
   };

   // One result transaction
   typedef struct packed {
      logic [7:0]  echo_byte;
      logic        is_text;
      logic [15:0] word_position;
      logic [1:0]  delimiter_kind;
      logic [2:0]  field_kind;
      logic [31:0] number_value;
      logic [7:0]  record_index;
      logic        all_done;
      logic        ignored;
   } result_type;

   // First keyword whose bytes all match the header prefix; unknown otherwise
   function automatic logic [2:0] match_header(input logic [63:0] prefix,
                                                input logic [15:0] len);
      logic [63:0] mask;
      logic [2:0]  kind;
      kind = KIND_UNKNOWN;
      for (int k = NUM_KEYS - 1; k >= 0; k--) begin
         for (int i = 0; i < 8; i++) begin
            mask[8*i +: 8] = (4'(i) < KEY_LEN[k]) ? 8'hFF : 8'h00;
         end
         if ((len >= 16'(KEY_LEN[k])) && ((prefix & mask) == KEY_TEXT[k])) begin
            kind = 3'(k);
         end
      end
      return kind;
   endfunction

endpackage

// ===== design/dlsp_parse.sv =====
// Parser state and per-byte result logic for the label stream parser.
// Depends on dlsp_pkg.
module dlsp_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          stream_byte,
   input  logic [7:0]          expected_records,
   output dlsp_pkg::result_type result
);

   logic [63:0]             header_prefix_ff, header_prefix_in;
   logic [15:0]             word_length_ff, word_length_in;
   logic [2:0]              current_kind_ff, current_kind_in;
   logic [31:0]             number_acc_ff, number_acc_in;
   logic                    number_neg_ff, number_neg_in;
   dlsp_pkg::num_phase_type number_phase_ff, number_phase_in;
   logic [7:0]              record_count_ff, record_count_in;
   logic                    finished_ff, finished_in;

   logic        done_now;
   logic        is_digit, is_blank;
   logic [7:0]  count_inc;
   logic [31:0] acc_times_ten;

   assign done_now      = finished_ff || (record_count_ff >= expected_records);
   assign is_digit      = (stream_byte >= 8'h30) && (stream_byte <= 8'h39);
   assign is_blank      = (stream_byte == 8'h20) ||
                          ((stream_byte >= 8'h09) && (stream_byte <= 8'h0D));
   assign acc_times_ten = {number_acc_ff[28:0], 3'b000} + {number_acc_ff[30:0], 1'b0};
   assign count_inc     = (record_count_ff < 8'hFF) ? record_count_ff + 8'd1
                                                    : record_count_ff;

   // Next state and result for the byte in the stage
   always_comb begin
      header_prefix_in = header_prefix_ff;
      word_length_in   = word_length_ff;
      current_kind_in  = current_kind_ff;
      number_acc_in    = number_acc_ff;
      number_neg_in    = number_neg_ff;
      number_phase_in  = number_phase_ff;
      record_count_in  = record_count_ff;
      finished_in      = done_now;

      result                = '0;
      result.echo_byte      = stream_byte;
      result.record_index   = record_count_ff;
      result.delimiter_kind = dlsp_pkg::DELIM_NONE;

      if (done_now) begin
         result.ignored = 1'b1;
      end else if (stream_byte >= dlsp_pkg::BYTE_TEXT_MIN) begin
         result.is_text       = 1'b1;
         result.word_position = word_length_ff;
         if (word_length_ff < 16'd8) begin
            header_prefix_in[{word_length_ff[2:0], 3'b000} +: 8] = stream_byte;
         end
         if (word_length_ff != 16'hFFFF) begin
            word_length_in = word_length_ff + 16'd1;
         end
         // atoi-style reading
         if (number_phase_ff != dlsp_pkg::PHASE_STOPPED) begin
            if (is_digit) begin
               number_acc_in   = acc_times_ten + {28'd0, stream_byte[3:0]};
               number_phase_in = dlsp_pkg::PHASE_DIGITS;
            end else if (number_phase_ff == dlsp_pkg::PHASE_BLANKS) begin
               if (is_blank) begin
                  number_phase_in = dlsp_pkg::PHASE_BLANKS;
               end else if (stream_byte == 8'h2B) begin
                  number_phase_in = dlsp_pkg::PHASE_SIGN;
               end else if (stream_byte == 8'h2D) begin
                  number_neg_in   = 1'b1;
                  number_phase_in = dlsp_pkg::PHASE_SIGN;
               end else begin
                  number_phase_in = dlsp_pkg::PHASE_STOPPED;
               end
            end else begin
               number_phase_in = dlsp_pkg::PHASE_STOPPED;
            end
         end
      end else if (stream_byte == dlsp_pkg::BYTE_PAD) begin
         result.ignored = 1'b1;
      end else begin
         // Any delimiter clears the word
         header_prefix_in = '0;
         word_length_in   = '0;
         number_acc_in    = '0;
         number_neg_in    = 1'b0;
         number_phase_in  = dlsp_pkg::PHASE_BLANKS;
         if (stream_byte == dlsp_pkg::BYTE_HEADER_END) begin
            result.delimiter_kind = dlsp_pkg::DELIM_HEADER;
            current_kind_in = dlsp_pkg::match_header(header_prefix_ff, word_length_ff);
         end else if (stream_byte == dlsp_pkg::BYTE_MEMBER_END) begin
            result.delimiter_kind = dlsp_pkg::DELIM_MEMBER;
            result.number_value   = number_neg_ff ? (32'd0 - number_acc_ff) : number_acc_ff;
         end else begin
            result.delimiter_kind = dlsp_pkg::DELIM_RECORD;
            record_count_in = count_inc;
            finished_in     = (count_inc >= expected_records);
         end
      end

      result.field_kind = current_kind_in;
      result.all_done   = finished_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_prefix_ff <= '0;
         word_length_ff   <= '0;
         current_kind_ff  <= dlsp_pkg::KIND_UNKNOWN;
         number_acc_ff    <= '0;
         number_neg_ff    <= 1'b0;
         number_phase_ff  <= dlsp_pkg::PHASE_BLANKS;
         record_count_ff  <= '0;
         finished_ff      <= 1'b0;
      end else if (step_en) begin
         header_prefix_ff <= header_prefix_in;
         word_length_ff   <= word_length_in;
         current_kind_ff  <= current_kind_in;
         number_acc_ff    <= number_acc_in;
         number_neg_ff    <= number_neg_in;
         number_phase_ff  <= number_phase_in;
         record_count_ff  <= record_count_in;
         finished_ff      <= finished_in;
      end
   end

endmodule

// ===== design/delimited_label_stream_parser_core.sv =====
// Top level of the delimited label stream parser: input register, parser, result register.
// Depends on dlsp_pkg and dlsp_parse.
//
//   channel   direction  payload                              handshake
//   req_      in         stream_byte                          req_valid / req_ready
//   rsp_      out        echo_byte .. ignored (9 fields)       rsp_valid / rsp_ready
//   csr_      in         expected_records                     csr_valid / csr_ready
//
// One byte per cycle sustained while the response is not stalled; a request passes
// through the input register, then the result register after the parser's single pass.
// The parser state is the only loop and updates once per transaction.
// Synchronous reset clears both stage valids and all parser state; the CSR resets to 0.
// A stalled response holds the result register and backs up into the input register;
// req_ready drops only when both are full.
module delimited_label_stream_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_echo_byte,
   output logic        rsp_is_text,
   output logic [15:0] rsp_word_position,
   output logic [1:0]  rsp_delimiter_kind,
   output logic [2:0]  rsp_field_kind,
   output logic [31:0] rsp_number_value,
   output logic [7:0]  rsp_record_index,
   output logic        rsp_all_done,
   output logic        rsp_ignored,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_expected_records
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 rsp_valid_ff;
   dlsp_pkg::result_type rsp_ff;
   dlsp_pkg::result_type step_result;
   logic [7:0]           expected_ff;
   logic                 out_load, advance, req_fire;

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_load;
   assign req_ready = !in_valid_ff || out_load;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
      end else if (csr_valid) begin
         expected_ff <= csr_expected_records;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   dlsp_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .step_en          (advance),
      .stream_byte      (in_byte_ff),
      .expected_records (expected_ff),
      .result           (step_result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_echo_byte      = rsp_ff.echo_byte;
   assign rsp_is_text        = rsp_ff.is_text;
   assign rsp_word_position  = rsp_ff.word_position;
   assign rsp_delimiter_kind = rsp_ff.delimiter_kind;
   assign rsp_field_kind     = rsp_ff.field_kind;
   assign rsp_number_value   = rsp_ff.number_value;
   assign rsp_record_index   = rsp_ff.record_index;
   assign rsp_all_done       = rsp_ff.all_done;
   assign rsp_ignored        = rsp_ff.ignored;

endmodule

// ===== design/dlsp_checker.sv =====
// Port-level checks for the label stream parser, bound to the top level.
// Depends on dlsp_pkg (codes) and delimited_label_stream_parser_core.
module dlsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_echo_byte,
   input logic        rsp_is_text,
   input logic [15:0] rsp_word_position,
   input logic [1:0]  rsp_delimiter_kind,
   input logic [31:0] rsp_number_value,
   input logic        rsp_all_done,
   input logic        rsp_ignored
);

   // A stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_echo_byte))
      else $error("response changed while stalled");

   // Text bytes are never delimiters nor ignored
   a_text_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_text |->
         rsp_delimiter_kind == dlsp_pkg::DELIM_NONE && !rsp_ignored)
      else $error("text byte flagged as delimiter or ignored");

   // A number is reported only at a member end
   a_number_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_delimiter_kind != dlsp_pkg::DELIM_MEMBER |-> rsp_number_value == 32'd0)
      else $error("number value outside member end");

   // Non-text bytes carry no word position
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_text |-> rsp_word_position == 16'd0)
      else $error("word position on non-text byte");

   // Before completion, only the pad byte is ignored
   a_ignore_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ignored && !rsp_all_done |-> rsp_echo_byte == dlsp_pkg::BYTE_PAD)
      else $error("non-pad byte ignored before completion");

endmodule

bind delimited_label_stream_parser_core dlsp_checker u_dlsp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_echo_byte      (rsp_echo_byte),
   .rsp_is_text        (rsp_is_text),
   .rsp_word_position  (rsp_word_position),
   .rsp_delimiter_kind (rsp_delimiter_kind),
   .rsp_number_value   (rsp_number_value),
   .rsp_all_done       (rsp_all_done),
   .rsp_ignored        (rsp_ignored)
);
